// File: hdl/mascon_pkg.sv
package mascon_pkg;

    // fixed field geometry
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = 5;
    localparam int ROUND_W    = 4;
    localparam int DEF_TOTAL_ROUNDS = 12;

    // stream payload widths
    localparam int IN_DATA_W  = 712;
    localparam int OUT_DATA_W = 704;

    typedef logic [WORD_W-1:0] word_t;

    // two xor shares of each state word
    typedef struct packed {
        word_t [NUM_WORDS-1:0] a;
        word_t [NUM_WORDS-1:0] b;
    } shares_t;

    // rotate right by a constant amount
    function automatic word_t rotr(input word_t v, input int n);
        word_t r;
        r = (v >> n) | (v << (WORD_W - n));
        return r;
    endfunction

    // linear diffusion of one word
    function automatic word_t diffuse(input word_t v, input int s1, input int s2);
        word_t r;
        r = v ^ rotr(v, s1) ^ rotr(v, s2);
        return r;
    endfunction

    // round constant: low byte holds the round index in its low nibble and its complement in its high nibble
    function automatic word_t round_const(input logic [ROUND_W-1:0] r);
        word_t c;
        c = {{(WORD_W - 2*ROUND_W){1'b0}}, ~r, r};
        return c;
    endfunction

endpackage

// File: hdl/mascon_round.sv
module mascon_round
    import mascon_pkg::*;
(
    input  shares_t              state_in,
    input  word_t                rnd_in,
    input  logic [ROUND_W-1:0]   round_idx,
    output shares_t              state_out,
    output word_t                rnd_out
);

    // one full masked round, applied by the sequencer once per cycle while rounds run
    always_comb
    begin
        word_t a0, a1, a2, a3, a4, b0, b1, b2, b3, b4;
        word_t ta, tb, ua, ub;
        word_t n0a, n0b, n1a, n1b, n2a, n2b, n3a, n3b;

        a0 = state_in.a[0]; a1 = state_in.a[1]; a2 = state_in.a[2];
        a3 = state_in.a[3]; a4 = state_in.a[4];
        b0 = state_in.b[0]; b1 = state_in.b[1]; b2 = state_in.b[2];
        b3 = state_in.b[3]; b4 = state_in.b[4];

        // constant addition on share a only
        a2 = a2 ^ round_const(round_idx);

        // substitution input mixing
        a0 = a0 ^ a4; a4 = a4 ^ a3; a2 = a2 ^ a1; ua = a0;
        b0 = b0 ^ b4; b4 = b4 ^ b3; b2 = b2 ^ b1; ub = b0;

        // masked chi, t0 seeded with the random word in both shares
        ta  = rnd_in ^ (~a0 & a1) ^ (~a0 & b1);
        tb  = rnd_in ^ (b0 & a1) ^ (b0 & b1);
        n0a = a0 ^ (~a1 & a2) ^ (~a1 & b2);
        n0b = b0 ^ (b1 & a2) ^ (b1 & b2);
        n1a = a1 ^ (~a2 & a3) ^ (~a2 & b3);
        n1b = b1 ^ (b2 & a3) ^ (b2 & b3);
        n2a = a2 ^ (~a3 & a4) ^ (~a3 & b4);
        n2b = b2 ^ (b3 & a4) ^ (b3 & b4);
        n3a = a3 ^ (~a4 & ua) ^ (~a4 & ub);
        n3b = b3 ^ (b4 & ua) ^ (b4 & ub);
        a0 = n0a; b0 = n0b; a1 = n1a; b1 = n1b;
        a2 = n2a; b2 = n2b; a3 = n3a; b3 = n3b;
        a4 = a4 ^ ta;
        b4 = b4 ^ tb;

        // substitution output mixing, complement on share a
        a1 = a1 ^ a0; a0 = a0 ^ a4; a3 = a3 ^ a2; a2 = ~a2;
        b1 = b1 ^ b0; b0 = b0 ^ b4; b3 = b3 ^ b2;

        // linear layer on both shares
        state_out.a[0] = diffuse(a0, 19, 28); state_out.b[0] = diffuse(b0, 19, 28);
        state_out.a[1] = diffuse(a1, 61, 39); state_out.b[1] = diffuse(b1, 61, 39);
        state_out.a[2] = diffuse(a2, 1, 6);   state_out.b[2] = diffuse(b2, 1, 6);
        state_out.a[3] = diffuse(a3, 10, 17); state_out.b[3] = diffuse(b3, 10, 17);
        state_out.a[4] = diffuse(a4, 7, 41);  state_out.b[4] = diffuse(b4, 7, 41);

        // refresh the random word
        rnd_out = rotr(ta, 13);
    end

endmodule

// File: hdl/masked_ascon_permutation.sv
// sequence: the request is loaded, then one round is applied for each round index from first_round
//   up to TOTAL_ROUNDS - 1 (none when first_round is at or beyond TOTAL_ROUNDS), then the result is offered
// requests: a new request is taken only after the result has been accepted, since the
//   single round unit, which the state register loops through once per cycle while running, serves one at a time
// reset: rst_n clears the sequencer to idle; state and random registers are not cleared
module masked_ascon_permutation
    import mascon_pkg::*;
#(
    parameter int TOTAL_ROUNDS = DEF_TOTAL_ROUNDS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // word0_share_a, word0_share_b, ... word4_share_b, random_in, first_round, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out0_share_a, out0_share_b, ... out4_share_b, random_out
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(TOTAL_ROUNDS - 1);
    localparam logic [ROUND_W-1:0] NUM_ROUNDS = ROUND_W'(TOTAL_ROUNDS);

    state_t              state_reg, state_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    shares_t             shares_reg, shares_next;
    word_t               rnd_reg, rnd_next;

    shares_t             in_shares, rnd_shares;
    word_t               in_rnd, rnd_word;
    logic [ROUND_W-1:0]  in_round;
    logic                in_accept, out_accept;

    // unpack the request
    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            in_shares.a[i] = s_axis_tdata[(2*i)*WORD_W +: WORD_W];
            in_shares.b[i] = s_axis_tdata[(2*i+1)*WORD_W +: WORD_W];
        end
        in_rnd   = s_axis_tdata[2*NUM_WORDS*WORD_W +: WORD_W];
        in_round = s_axis_tdata[(2*NUM_WORDS+1)*WORD_W +: ROUND_W];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    // shared round unit
    mascon_round u_round (
        .state_in  (shares_reg),
        .rnd_in    (rnd_reg),
        .round_idx (round_reg),
        .state_out (rnd_shares),
        .rnd_out   (rnd_word)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        shares_next = shares_reg;
        rnd_next    = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    shares_next = in_shares;
                    rnd_next    = in_rnd;
                    round_next  = in_round;
                    state_next  = (in_round < NUM_ROUNDS) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                shares_next = rnd_shares;
                rnd_next    = rnd_word;
                round_next  = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // state and random word
    always_ff @(posedge clk)
    begin
        shares_reg <= shares_next;
        rnd_reg    <= rnd_next;
    end

    // pack the result
    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            m_axis_tdata[(2*i)*WORD_W +: WORD_W]   = shares_reg.a[i];
            m_axis_tdata[(2*i+1)*WORD_W +: WORD_W] = shares_reg.b[i];
        end
        m_axis_tdata[2*NUM_WORDS*WORD_W +: WORD_W] = rnd_reg;
    end

    // the round counter stays inside the schedule while rounds run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (round_reg < NUM_ROUNDS))
        else $error("round counter beyond the last round while running");

    // the last round hands over to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && round_reg == LAST_ROUND) |=> m_axis_tvalid)
        else $error("result not offered after the last round");

    // a request with no rounds to run goes straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_round >= NUM_ROUNDS) |=> m_axis_tvalid)
        else $error("pass-through request not offered at once");

    // never take a request while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

endmodule
